FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the touch point scale filter
// Screen geometry, field widths, register indexes, reset values and the
// reciprocal used for the divide by 1000.
// ----------------------------------------------------------------------------
package tps_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    // field widths
    localparam int WORD_W  = 32;
    localparam int COORD_W = 12;
    localparam int POSY_W  = 13;
    localparam int SIZE_W  = 13;
    localparam int OUT_W   = 32;
    localparam int THR_W   = 8;
    localparam int SLOPE_W = 16;
    localparam int ICPT_W  = 24;

    // raw field positions in the sample word
    localparam int RAW_X_LSB = 20;
    localparam int RAW_Y_LSB = 8;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_CORR_EN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_X_SLOPE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_X_ICPT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_SLOPE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_ICPT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MOVE_TH = 3'd5;

    localparam logic signed [SLOPE_W-1:0] RST_SLOPE = 16'sd1000;
    localparam logic [THR_W-1:0]          RST_THR   = 8'd5;

    // shared multiplier: 24 x 24 signed operands, 48-bit product
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // corrected numerator (signed), and the divide by 1000
    localparam int NUM_W   = 30;
    localparam int DIV_N_W = 22;
    localparam int RECIP_SHIFT = 32;
    // ceil(2^32 / 1000): exact for numerators below 2^22 / 704 margin
    localparam logic [22:0] RECIP_1000 = 23'd4294968;

    // per-axis constants
    localparam logic [SIZE_W-1:0]  SIZE_X  = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0]  SIZE_Y  = SIZE_W'(SCREEN_HEIGHT);
    localparam logic [COORD_W-1:0] MAX_X   = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0] MAX_Y   = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [NUM_W-2:0]   LIMIT_X = (NUM_W-1)'(SCREEN_WIDTH * 1000);
    localparam logic [NUM_W-2:0]   LIMIT_Y = (NUM_W-1)'(SCREEN_HEIGHT * 1000);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
    } t_raw_point;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: src/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front: sample intake
// Takes raw sample words, pulls out the X and Y fields and pushes the pair
// into the point queue through a one-entry holding register.
// ----------------------------------------------------------------------------
module tps_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [tps_pkg::WORD_W-1:0]    i_s_axis_tdata,   // [31:0] fifo_word
    input  tps_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output tps_pkg::t_raw_point           o_point
);

    logic                r_valid;
    tps_pkg::t_raw_point r_point;
    logic                w_take;

    assign o_s_axis_tready = !r_valid || !i_q_status.full;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_q_status.full;
    assign o_point         = r_point;

    // holding register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // field extraction
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_point.rx <= i_s_axis_tdata[tps_pkg::RAW_X_LSB +: tps_pkg::COORD_W];
            r_point.ry <= i_s_axis_tdata[tps_pkg::RAW_Y_LSB +: tps_pkg::COORD_W];
        end
    end

endmodule

FILE: src/tps_queue.sv
// ----------------------------------------------------------------------------
// tps_queue: point queue
// Short first-in first-out queue of raw points between intake and the
// arithmetic sequencer.
// ----------------------------------------------------------------------------
module tps_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tps_pkg::t_raw_point  i_point,
    input  logic                 i_pop,
    output tps_pkg::t_raw_point  o_point,
    output tps_pkg::t_q_status   o_status
);

    tps_pkg::t_raw_point               r_mem [tps_pkg::QUEUE_DEPTH];
    logic [tps_pkg::QPTR_W-1:0]        r_wptr;
    logic [tps_pkg::QPTR_W-1:0]        r_rptr;
    logic [tps_pkg::QCNT_W-1:0]        r_count;
    logic                              w_push;
    logic                              w_pop;

    assign o_status.full  = (r_count == tps_pkg::QCNT_W'(tps_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_point        = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == tps_pkg::QPTR_W'(tps_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == tps_pkg::QPTR_W'(tps_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_point;
        end
    end

endmodule

FILE: src/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back: scale, correct and filter sequencer
// One shared multiplier steps each axis through scaling, optional linear
// correction and a reciprocal divide by 1000, then applies the movement
// threshold and loads the output register. Holds the config registers.
// ----------------------------------------------------------------------------
module tps_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  tps_pkg::t_q_status              i_q_status,
    input  tps_pkg::t_raw_point             i_point,
    output logic                            o_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [tps_pkg::OUT_W-1:0]       o_m_axis_tdata  // [11:0] pos_x, [24:12] pos_y,
                                                            // [25] moved
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_CORR   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_QUOT   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    // configuration registers
    logic                                r_corr_en;
    logic signed [tps_pkg::SLOPE_W-1:0]  r_x_slope;
    logic signed [tps_pkg::ICPT_W-1:0]   r_x_icpt;
    logic signed [tps_pkg::SLOPE_W-1:0]  r_y_slope;
    logic signed [tps_pkg::ICPT_W-1:0]   r_y_icpt;
    logic [tps_pkg::THR_W-1:0]           r_thr;

    // sequencer and datapath
    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic                                r_axis;
    logic                                n_axis;
    tps_pkg::t_raw_point                 r_raw;
    logic signed [tps_pkg::PROD_W-1:0]   r_prod;
    logic [tps_pkg::COORD_W-1:0]         r_res_x;
    logic [tps_pkg::COORD_W-1:0]         r_res_y;
    logic [tps_pkg::COORD_W-1:0]         r_held_x;
    logic [tps_pkg::COORD_W-1:0]         r_held_y;
    logic                                r_out_valid;
    logic [tps_pkg::COORD_W-1:0]         r_out_x;
    logic [tps_pkg::POSY_W-1:0]          r_out_y;
    logic                                r_out_moved;

    logic signed [tps_pkg::MUL_W-1:0]    w_mul_a;
    logic signed [tps_pkg::MUL_W-1:0]    w_mul_b;
    logic [tps_pkg::COORD_W-1:0]         w_raw;
    logic [tps_pkg::SIZE_W-1:0]          w_size;
    logic [tps_pkg::COORD_W-1:0]         w_max;
    logic [tps_pkg::NUM_W-2:0]           w_limit;
    logic signed [tps_pkg::SLOPE_W-1:0]  w_slope;
    logic signed [tps_pkg::ICPT_W-1:0]   w_icpt;
    logic [tps_pkg::COORD_W-1:0]         w_scaled;
    logic [tps_pkg::COORD_W-1:0]         w_clamped;
    logic signed [tps_pkg::NUM_W-1:0]    w_num;
    logic [tps_pkg::COORD_W-1:0]         w_quot;
    logic                                w_axis_done;
    logic [tps_pkg::COORD_W-1:0]         w_axis_res;
    logic [tps_pkg::COORD_W-1:0]         w_dx;
    logic [tps_pkg::COORD_W-1:0]         w_dy;
    logic [tps_pkg::COORD_W:0]           w_dist;
    logic                                w_move;
    logic                                w_out_free;
    logic [tps_pkg::COORD_W-1:0]         w_new_x;
    logic [tps_pkg::COORD_W-1:0]         w_new_y;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_en <= 1'b0;
            r_x_slope <= tps_pkg::RST_SLOPE;
            r_x_icpt  <= '0;
            r_y_slope <= tps_pkg::RST_SLOPE;
            r_y_icpt  <= '0;
            r_thr     <= tps_pkg::RST_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tps_pkg::REG_CORR_EN: r_corr_en <= i_cfg_wdata[0];
                tps_pkg::REG_X_SLOPE: r_x_slope <= i_cfg_wdata[tps_pkg::SLOPE_W-1:0];
                tps_pkg::REG_X_ICPT:  r_x_icpt  <= i_cfg_wdata[tps_pkg::ICPT_W-1:0];
                tps_pkg::REG_Y_SLOPE: r_y_slope <= i_cfg_wdata[tps_pkg::SLOPE_W-1:0];
                tps_pkg::REG_Y_ICPT:  r_y_icpt  <= i_cfg_wdata[tps_pkg::ICPT_W-1:0];
                tps_pkg::REG_MOVE_TH: r_thr     <= i_cfg_wdata[tps_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // per-axis selection
    assign w_raw   = r_axis ? r_raw.ry : r_raw.rx;
    assign w_size  = r_axis ? tps_pkg::SIZE_Y : tps_pkg::SIZE_X;
    assign w_max   = r_axis ? tps_pkg::MAX_Y : tps_pkg::MAX_X;
    assign w_limit = r_axis ? tps_pkg::LIMIT_Y : tps_pkg::LIMIT_X;
    assign w_slope = r_axis ? r_y_slope : r_x_slope;
    assign w_icpt  = r_axis ? r_y_icpt : r_x_icpt;

    // scaled value (raw * size) >> 12, clamped to size - 1
    assign w_scaled  = r_prod[2*tps_pkg::COORD_W-1:tps_pkg::COORD_W];
    assign w_clamped = ({1'b0, w_scaled} >= w_size) ? w_max : w_scaled;

    // corrected numerator and quotient
    assign w_num  = r_prod[tps_pkg::NUM_W-1:0]
                  + {{(tps_pkg::NUM_W-tps_pkg::ICPT_W){w_icpt[tps_pkg::ICPT_W-1]}}, w_icpt};
    assign w_quot = r_prod[tps_pkg::RECIP_SHIFT +: tps_pkg::COORD_W];

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_SCALE: begin
                w_mul_a = {{(tps_pkg::MUL_W-tps_pkg::COORD_W){1'b0}}, w_raw};
                w_mul_b = {{(tps_pkg::MUL_W-tps_pkg::SIZE_W){1'b0}}, w_size};
            end
            S_CORR: begin
                w_mul_a = {{(tps_pkg::MUL_W-tps_pkg::COORD_W){1'b0}}, w_scaled};
                w_mul_b = {{(tps_pkg::MUL_W-tps_pkg::SLOPE_W){w_slope[tps_pkg::SLOPE_W-1]}},
                           w_slope};
            end
            S_DIV: begin
                w_mul_a = {{(tps_pkg::MUL_W-tps_pkg::DIV_N_W){1'b0}},
                           w_num[tps_pkg::DIV_N_W-1:0]};
                w_mul_b = {1'b0, tps_pkg::RECIP_1000};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // distance to held point and threshold test
    assign w_new_x    = r_res_x;
    assign w_new_y    = r_res_y;
    assign w_dx       = (w_new_x > r_held_x) ? w_new_x - r_held_x : r_held_x - w_new_x;
    assign w_dy       = (w_new_y > r_held_y) ? w_new_y - r_held_y : r_held_y - w_new_y;
    assign w_dist     = {1'b0, w_dx} + {1'b0, w_dy};
    assign w_move     = w_dist > {{(tps_pkg::COORD_W+1-tps_pkg::THR_W){1'b0}}, r_thr};
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        w_axis_done = 1'b0;
        w_axis_res  = w_clamped;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_axis  = 1'b0;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_CORR;
            S_CORR: begin
                if (r_corr_en) begin
                    n_state = S_DIV;
                end else begin
                    w_axis_done = 1'b1;
                end
            end
            S_DIV: begin
                // negative saturates to zero, large values clamp to the edge
                if (w_num[tps_pkg::NUM_W-1]) begin
                    w_axis_done = 1'b1;
                    w_axis_res  = '0;
                end else if (w_num[tps_pkg::NUM_W-2:0] >= w_limit) begin
                    w_axis_done = 1'b1;
                    w_axis_res  = w_max;
                end else begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                w_axis_done = 1'b1;
                w_axis_res  = w_quot;
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_axis_done) begin
            if (r_axis) begin
                n_state = S_DECIDE;
            end else begin
                n_axis  = 1'b1;
                n_state = S_SCALE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // raw point capture and per-axis results
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_raw <= i_point;
        end
        if (w_axis_done && !r_axis) begin
            r_res_x <= w_axis_res;
        end
        if (w_axis_done && r_axis) begin
            r_res_y <= w_axis_res;
        end
    end

    // held position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (r_state == S_DECIDE && w_out_free && w_move) begin
            r_held_x <= w_new_x;
            r_held_y <= w_new_y;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DECIDE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && w_out_free) begin
            r_out_x     <= w_move ? w_new_x : r_held_x;
            r_out_y     <= tps_pkg::SIZE_Y - {1'b0, (w_move ? w_new_y : r_held_y)};
            r_out_moved <= w_move;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tps_pkg::OUT_W-tps_pkg::COORD_W-tps_pkg::POSY_W-1){1'b0}},
                              r_out_moved, r_out_y, r_out_x};

endmodule

FILE: src/touch_point_scale_filter.sv
// Flow: intake holding register, point queue, back sequencer, output register.
// Intake and queue take further samples while the back sequencer works on one point, until
//   the queue fills. The sequencer fetches a point, steps each axis through scale and slope,
//   plus divide and quotient with correction, then a threshold step that waits for the output.
// Reset: synchronous active low; clears held position to zero, loads register reset
//   values, empties the queue and drops output valid.
// ----------------------------------------------------------------------------
// touch_point_scale_filter: touch sample scaling with movement hysteresis
// Intake stage and queue feed a multiply sequencer that maps raw X/Y to
// screen pixels and only updates the held point on a large enough move.
// ----------------------------------------------------------------------------
module touch_point_scale_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [tps_pkg::WORD_W-1:0]      i_s_axis_tdata,  // [31:0] fifo_word
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [tps_pkg::OUT_W-1:0]       o_m_axis_tdata,  // [11:0] pos_x, [24:12] pos_y,
                                                             // [25] moved, [31:26] zero
    input  logic                            i_cfg_we,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    tps_pkg::t_q_status  w_q_status;
    tps_pkg::t_raw_point w_push_point;
    tps_pkg::t_raw_point w_head_point;
    logic                w_push;
    logic                w_pop;

    tps_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_point         (w_push_point)
    );

    tps_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_point  (w_push_point),
        .i_pop    (w_pop),
        .o_point  (w_head_point),
        .o_status (w_q_status)
    );

    tps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_status      (w_q_status),
        .i_point         (w_head_point),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

FILE: src/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker: port-level checks for the touch point scale filter
// Tracks the last delivered position and checks the moved flag against it,
// the range against the screen, reset and stall holding; bound onto the top level.
// ----------------------------------------------------------------------------
module tps_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [tps_pkg::OUT_W-1:0]   i_m_tdata
);

    logic [tps_pkg::COORD_W-1:0] r_last_x;
    logic [tps_pkg::POSY_W-1:0]  r_last_y;
    logic                        w_out_acc;
    logic [tps_pkg::COORD_W-1:0] w_pos_x;
    logic [tps_pkg::POSY_W-1:0]  w_pos_y;
    logic                        w_moved;

    assign w_out_acc = i_m_tvalid && i_m_tready;
    assign w_pos_x   = i_m_tdata[tps_pkg::COORD_W-1:0];
    assign w_pos_y   = i_m_tdata[tps_pkg::COORD_W +: tps_pkg::POSY_W];
    assign w_moved   = i_m_tdata[tps_pkg::COORD_W + tps_pkg::POSY_W];

    // last delivered position, starts at the reset point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= tps_pkg::SIZE_Y;
        end else if (w_out_acc) begin
            r_last_x <= w_pos_x;
            r_last_y <= w_pos_y;
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled output request changed");

    a_still_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !w_moved |-> w_pos_x == r_last_x && w_pos_y == r_last_y)
        else $error("position changed without move");

    a_move_changes_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && w_moved |-> w_pos_x != r_last_x || w_pos_y != r_last_y)
        else $error("move flagged with same position");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> {1'b0, w_pos_x} < tps_pkg::SIZE_X && w_pos_y != '0
                       && w_pos_y <= tps_pkg::SIZE_Y)
        else $error("position outside screen");

endmodule

bind touch_point_scale_filter tps_checker u_tps_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
